### hdl/acb32_pkg.sv
// ---------------------------------------------------------------------------
// acb32_pkg
// Shared types, constants and functions of the base32 account-id encoder.
// ---------------------------------------------------------------------------
package acb32_pkg;

   localparam int unsigned POS_W       = 6;
   localparam int unsigned ACC_W       = 12;
   localparam int unsigned PEND_W      = 4;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_INIT      = 16'h0000;
   localparam logic [7:0]  VERSION_RESET = 8'd48;

   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_DIGIT_2 = 7'h32;
   localparam logic [4:0] ALPHA_COUNT  = 5'd26;

   // byte slot within one queue entry
   localparam logic [1:0] SLOT_VERSION = 2'd0;
   localparam logic [1:0] SLOT_KEY     = 2'd1;
   localparam logic [1:0] SLOT_CRC_LO  = 2'd2;
   localparam logic [1:0] SLOT_CRC_HI  = 2'd3;

   typedef struct packed {
      logic [7:0]  key;
      logic [7:0]  version;
      logic [15:0] crc;
      logic        first;
      logic        last;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } q_status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [6:0] b32_char(input logic [4:0] v);
      logic [6:0] r;
      if (v < ALPHA_COUNT) begin
         r = CHAR_UPPER_A + {2'b00, v};
      end else begin
         r = CHAR_DIGIT_2 + {2'b00, v} - {2'b00, ALPHA_COUNT};
      end
      return r;
   endfunction

endpackage

### hdl/acb32_req_if.sv
// ---------------------------------------------------------------------------
// acb32_req_if
// Key byte input channel.
// ---------------------------------------------------------------------------
interface acb32_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_byte;

   modport source (output valid, output key_byte, input ready);
   modport sink   (input valid, input key_byte, output ready);
endinterface

### hdl/acb32_rsp_if.sv
// ---------------------------------------------------------------------------
// acb32_rsp_if
// Base32 character result channel.
// ---------------------------------------------------------------------------
interface acb32_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] text_char;
   logic       last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

### hdl/acb32_csr_if.sv
// ---------------------------------------------------------------------------
// acb32_csr_if
// Version byte register write channel.
// ---------------------------------------------------------------------------
interface acb32_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] version_byte;

   modport source (output valid, output version_byte, input ready);
   modport sink   (input valid, input version_byte, output ready);
endinterface

### hdl/acb32_front.sv
// ---------------------------------------------------------------------------
// acb32_front
// Accepts key bytes, tracks byte position and running crc, tags each beat.
// ---------------------------------------------------------------------------
module acb32_front
   import acb32_pkg::*;
#(
   parameter int unsigned KEY_BYTES = 32
) (
   input  logic           clock,
   input  logic           reset,
   acb32_req_if.sink      req_bus,
   acb32_csr_if.sink      csr_bus,
   input  q_status_type   q_stat,
   output logic           push,
   output q_entry_type    push_entry
);

   logic [7:0]       version_ff, version_in;
   logic [15:0]      ver_crc_ff, ver_crc_in;
   logic [15:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             first;
   logic             last;
   logic [15:0]      crc_base;
   logic [15:0]      crc_new;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !q_stat.full;
   assign push          = req_bus.valid && req_bus.ready;

   assign first    = (pos_ff == '0);
   assign last     = (pos_ff == POS_W'(KEY_BYTES - 1));
   // crc of the version byte alone is kept ready so only one byte step sits here
   assign crc_base = first ? ver_crc_ff : crc_ff;
   assign crc_new  = crc_byte(crc_base, req_bus.key_byte);

   always_comb begin
      push_entry.key     = req_bus.key_byte;
      push_entry.version = version_ff;
      push_entry.crc     = crc_new;
      push_entry.first   = first;
      push_entry.last    = last;
   end

   always_comb begin
      version_in = version_ff;
      ver_crc_in = ver_crc_ff;
      crc_in     = crc_ff;
      pos_in     = pos_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         version_in = csr_bus.version_byte;
         ver_crc_in = crc_byte(CRC_INIT, csr_bus.version_byte);
      end
      if (push) begin
         crc_in = crc_new;
         pos_in = last ? '0 : pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
         ver_crc_ff <= crc_byte(CRC_INIT, VERSION_RESET);
         crc_ff     <= CRC_INIT;
         pos_ff     <= '0;
      end else begin
         version_ff <= version_in;
         ver_crc_ff <= ver_crc_in;
         crc_ff     <= crc_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

### hdl/acb32_queue.sv
// ---------------------------------------------------------------------------
// acb32_queue
// Short fifo of tagged key beats between front and back.
// ---------------------------------------------------------------------------
module acb32_queue
   import acb32_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  q_entry_type   push_entry,
   input  logic          pop,
   output q_status_type  q_stat,
   output q_entry_type   head
);

   q_entry_type       mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_stat.full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.head_valid = (count_ff != '0);
   assign head              = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/acb32_back.sv
// ---------------------------------------------------------------------------
// acb32_back
// Streams payload bytes via a bit accumulator, one char per unstalled cycle.
// ---------------------------------------------------------------------------
module acb32_back
   import acb32_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  q_status_type  q_stat,
   input  q_entry_type   head,
   output logic          pop,
   acb32_rsp_if.source   rsp_bus
);

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              tail_ff, tail_in;
   logic              started_ff, started_in;
   logic [1:0]        slot_ff, slot_in;
   logic              out_valid_ff, out_valid_in;
   logic [6:0]        out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;

   logic              fire;
   logic              do_drain;
   logic              do_flush;
   logic              do_load;
   logic [1:0]        slot_cur;
   logic [1:0]        slot_end;
   logic [7:0]        slot_byte;
   logic [ACC_W-1:0]  load_acc;
   logic [PEND_W-1:0] load_pend;
   logic [PEND_W-1:0] rem_pend;
   logic [4:0]        value;

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.text_char = out_char_ff;
   assign rsp_bus.last_char = out_last_ff;

   assign fire     = !out_valid_ff || rsp_bus.ready;
   assign do_drain = (pend_ff >= PEND_W'(5));
   // leftover bits of a finished text go out before the next text starts
   assign do_flush = !do_drain && tail_ff;
   assign do_load  = !do_drain && !tail_ff && q_stat.head_valid;

   assign slot_cur = started_ff ? slot_ff : (head.first ? SLOT_VERSION : SLOT_KEY);
   assign slot_end = head.last ? SLOT_CRC_HI : SLOT_KEY;

   always_comb begin
      case (slot_cur)
         SLOT_VERSION: slot_byte = head.version;
         SLOT_KEY:     slot_byte = head.key;
         SLOT_CRC_LO:  slot_byte = head.crc[7:0];
         SLOT_CRC_HI:  slot_byte = head.crc[15:8];
         default:      slot_byte = head.key;
      endcase
   end

   assign load_acc  = {acc_ff[3:0], slot_byte};
   assign load_pend = pend_ff + PEND_W'(8);
   assign rem_pend  = do_load ? load_pend - PEND_W'(5) : pend_ff - PEND_W'(5);

   always_comb begin
      if (do_load) begin
         value = 5'(load_acc >> rem_pend);
      end else if (do_drain) begin
         value = 5'(acc_ff >> rem_pend);
      end else begin
         value = 5'(acc_ff << (PEND_W'(5) - pend_ff));
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      tail_in      = tail_ff;
      started_in   = started_ff;
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      if (fire) begin
         out_valid_in = do_drain || do_flush || do_load;
         out_char_in  = b32_char(value);
         out_last_in  = 1'b0;
         if (do_drain) begin
            pend_in = rem_pend;
            if (tail_ff && rem_pend == '0) begin
               out_last_in = 1'b1;
               tail_in     = 1'b0;
            end
         end else if (do_flush) begin
            pend_in     = '0;
            tail_in     = 1'b0;
            out_last_in = 1'b1;
         end else if (do_load) begin
            acc_in  = load_acc;
            pend_in = rem_pend;
            if (slot_cur == slot_end) begin
               pop        = 1'b1;
               started_in = 1'b0;
               if (head.last) begin
                  tail_in     = (rem_pend != '0);
                  out_last_in = (rem_pend == '0);
               end
            end else begin
               started_in = 1'b1;
               slot_in    = slot_cur + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         tail_ff      <= 1'b0;
         started_ff   <= 1'b0;
         slot_ff      <= SLOT_VERSION;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         tail_ff      <= tail_in;
         started_ff   <= started_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
      acc_ff      <= acc_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

### hdl/account_id_base32_crc_encoder.sv
// A key beat's characters pass through its queue entry and then the result register.
// The back end emits one character per cycle while the result channel is ready; the
// first byte of a text also carries the version byte, the final byte the crc bytes.
// The front takes a beat in every cycle in which the 2-entry queue has room.
// Reset (synchronous, active high) restores version byte 48, clears position, crc,
// pending bits and all queue and result valids.
// ---------------------------------------------------------------------------
// account_id_base32_crc_encoder
// Version byte, key and crc-16/xmodem encoded as unpadded base32 text.
// ---------------------------------------------------------------------------
module account_id_base32_crc_encoder
   import acb32_pkg::*;
#(
   parameter int unsigned KEY_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   acb32_req_if.sink   req_bus,
   acb32_csr_if.sink   csr_bus,
   acb32_rsp_if.source rsp_bus
);

   q_status_type q_stat;
   q_entry_type  push_entry;
   q_entry_type  head;
   logic         push;
   logic         pop;

   acb32_front #(
      .KEY_BYTES (KEY_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   acb32_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_stat     (q_stat),
      .head       (head)
   );

   acb32_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

   // every character beat is a legal base32 letter or digit
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((rsp_bus.text_char >= 7'h41 && rsp_bus.text_char <= 7'h5A) ||
                         (rsp_bus.text_char >= 7'h32 && rsp_bus.text_char <= 7'h37)))
      else $error("illegal base32 character on result channel");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.head_valid)
      else $error("queue read while empty");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

endmodule
